// ===== sv/twr_pkg.sv =====
// twr_pkg: transaction types and fixed codes for the timer wheel ring
// no dependencies; imported by timer_wheel_ring
`timescale 1ns / 1ps
`default_nettype none

package twr_pkg;

    localparam int ID_W = 32;
    localparam int MAX_SCALE = 14;

    // command codes
    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_DELETE  = 3'd1;
    localparam logic [2:0] CMD_ADVANCE = 3'd2;
    localparam logic [2:0] CMD_RST_POS = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    typedef struct packed {
        logic [2:0]      command;
        logic [7:0]      slot;
        logic [ID_W-1:0] tmr_id;
        logic [3:0]      scale;
    } in_item_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic            accepted;
        logic            slot_full;
        logic [ID_W-1:0] fired_id;
        logic [1:0]      level_tag;
        logic            wrapped;
        logic [3:0]      remaining_scale;
        logic            last;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/timer_wheel_ring.sv =====
// timer_wheel_ring: one ring of a hashed timing wheel, slot rows kept in one ram
// depends on twr_pkg and twr_ram
//
// Usage:
//   in channel (in_valid / in_stall / in_data) carries commands: add, delete,
//   advance, reset position, clear. out channel (out_valid / out_stall /
//   out_data) returns results; the final result of each command has last set.
//   cfg_wr_en / cfg_wr_data write ring_level; the user must write it only while
//   the block is idle, as the block itself does not enforce this.
// Command sequencing:
//   add, delete: slot row read, then checked and written, then result loaded;
//   an add refused by the level check goes straight to its result, as do reset
//   position and unknown codes. clear: one ram row cleared per cycle, then the ack.
//   advance: per fired slot a row read, the rank of each entry, then the fired ids
//   in ascending order as the output register frees, then the end result.
//   The ranking pass over each slot row sets the advance rate.
// Reset: position and ring_level go to 0 and a clearing pass over all SLOT_COUNT
//   rows empties every slot; in_stall stays high during that pass.
// Stall: a result sits in the output register while out_stall is high; the
//   block accepts the next command once its own last result is loaded.
`timescale 1ns / 1ps
`default_nettype none

module timer_wheel_ring #(
    parameter int SLOT_COUNT    = 256,
    parameter int SLOT_CAPACITY = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [1:0]       cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  twr_pkg::in_item_t     in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output twr_pkg::out_item_t    out_data
);

    import twr_pkg::*;

    localparam int PW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW   = ((PW > 4) ? PW : 4) + 1;
    localparam int RW   = $clog2(SLOT_CAPACITY + 1);
    localparam int IW   = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
    localparam int ROWW = SLOT_CAPACITY * (ID_W + 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ADD   = 4'd2;
    localparam logic [3:0] S_DEL   = 4'd3;
    localparam logic [3:0] S_FLAT  = 4'd4;
    localparam logic [3:0] S_FRANK = 4'd5;
    localparam logic [3:0] S_FEMIT = 4'd6;
    localparam logic [3:0] S_RES   = 4'd7;

    // control registers
    logic [3:0]    state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [1:0]    level_reg;
    logic [PW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_ack_reg, clr_ack_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    in_item_t      item_reg, item_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] end_reg, end_next;
    out_item_t     res_reg, res_next;
    out_item_t     out_data_reg, out_data_next;
    logic [ID_W-1:0] ids_reg [SLOT_CAPACITY];
    logic [ID_W-1:0] ids_next [SLOT_CAPACITY];
    logic [SLOT_CAPACITY-1:0] mask_reg, mask_next;
    logic [RW-1:0] rank_reg [SLOT_CAPACITY];
    logic [RW-1:0] rank_next [SLOT_CAPACITY];
    logic [IW-1:0] ridx_reg, ridx_next;
    logic [RW-1:0] k_reg, k_next;

    // ram port
    logic            mem_we;
    logic [PW-1:0]   mem_waddr;
    logic [ROWW-1:0] mem_wdata;
    logic [PW-1:0]   mem_raddr;
    logic [ROWW-1:0] mem_rdata;

    // helpers
    logic          can_emit;
    logic          out_load;
    logic [3:0]    scale_sat;
    logic [CW-1:0] sum_w;
    logic [SLOT_CAPACITY-1:0] row_mask;
    logic [ID_W-1:0] row_id [SLOT_CAPACITY];
    logic          row_dup;
    logic          row_has_free;
    logic [IW-1:0] row_free;
    logic [SLOT_CAPACITY-1:0] row_hit;
    logic [RW-1:0] rank_cnt;
    logic [RW-1:0] fire_n;
    logic [ID_W-1:0] fire_id;

    twr_ram #(
        .WIDTH(ROWW),
        .DEPTH(SLOT_COUNT)
    ) u_rows (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    function automatic logic [PW-1:0] slot_of(input logic [CW-1:0] c);
        return (c == CW'(SLOT_COUNT)) ? '0 : c[PW-1:0];
    endfunction

    function automatic out_item_t make_res(input logic [1:0] kind, input logic acc,
                                           input logic full, input logic [ID_W-1:0] id,
                                           input logic [1:0] tag, input logic wrap,
                                           input logic [3:0] rem, input logic last);
        out_item_t r;
        r.kind            = kind;
        r.accepted        = acc;
        r.slot_full       = full;
        r.fired_id        = id;
        r.level_tag       = tag;
        r.wrapped         = wrap;
        r.remaining_scale = rem;
        r.last            = last;
        return r;
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign can_emit  = !out_valid_reg || !out_stall;

    // input decode
    assign scale_sat = (in_data.scale > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : in_data.scale;
    assign sum_w     = CW'(pos_reg) + CW'(scale_sat);

    // row decode of the word read from ram
    always_comb
    begin
        row_mask     = mem_rdata[SLOT_CAPACITY-1:0];
        row_dup      = 1'b0;
        row_has_free = 1'b0;
        row_free     = '0;
        for (int i = 0; i < SLOT_CAPACITY; i++)
        begin
            row_id[i]  = mem_rdata[SLOT_CAPACITY + ID_W*i +: ID_W];
            row_hit[i] = row_mask[i] && (row_id[i] == item_reg.tmr_id);
            if (row_hit[i])
            begin
                row_dup = 1'b1;
            end
        end
        for (int i = SLOT_CAPACITY - 1; i >= 0; i--)
        begin
            if (!row_mask[i])
            begin
                row_has_free = 1'b1;
                row_free     = IW'(i);
            end
        end
    end

    // rank of one entry, fired count and selected fired id
    always_comb
    begin
        rank_cnt = '0;
        fire_n   = '0;
        fire_id  = '0;
        for (int j = 0; j < SLOT_CAPACITY; j++)
        begin
            if (mask_reg[j] && (ids_reg[j] < ids_reg[ridx_reg]))
            begin
                rank_cnt = rank_cnt + RW'(1);
            end
            if (mask_reg[j])
            begin
                fire_n = fire_n + RW'(1);
            end
            if (mask_reg[j] && (rank_reg[j] == k_reg))
            begin
                fire_id = fire_id | ids_reg[j];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        clr_addr_next = clr_addr_reg;
        clr_ack_next  = clr_ack_reg;
        item_next     = item_reg;
        cur_next      = cur_reg;
        end_next      = end_reg;
        res_next      = res_reg;
        ids_next      = ids_reg;
        mask_next     = mask_reg;
        rank_next     = rank_reg;
        ridx_next     = ridx_reg;
        k_next        = k_reg;
        out_load      = 1'b0;
        out_data_next = out_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = PW'(item_reg.slot);
        mem_wdata     = mem_rdata;
        mem_raddr     = PW'(in_data.slot);

        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == PW'(SLOT_COUNT - 1))
                begin
                    clr_addr_next = '0;
                    clr_ack_next  = 1'b0;
                    state_next    = clr_ack_reg ? S_RES : S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + PW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    res_next  = make_res(KIND_ACK, 1'b0, 1'b0, '0, 2'd0, 1'b0, 4'd0, 1'b1);
                    state_next = S_RES;
                    unique case (in_data.command)
                        CMD_ADD:
                        begin
                            res_next = make_res(KIND_ADD, 1'b0, 1'b0, '0, 2'd0, 1'b0, 4'd0,
                                                1'b1);
                            if (32'(in_data.slot) < 32'(SLOT_COUNT) &&
                                !(32'(in_data.slot) == 32'(pos_reg) && level_reg != 2'd0))
                            begin
                                state_next = S_ADD;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (32'(in_data.slot) < 32'(SLOT_COUNT))
                            begin
                                state_next = S_DEL;
                            end
                        end
                        CMD_ADVANCE:
                        begin
                            res_next = make_res(KIND_END, 1'b0, 1'b0, '0, 2'd0, 1'b0, 4'd0,
                                                1'b1);
                            if (scale_sat != 4'd0)
                            begin
                                if (sum_w >= CW'(SLOT_COUNT))
                                begin
                                    end_next = CW'(SLOT_COUNT);
                                    res_next.wrapped = 1'b1;
                                    res_next.remaining_scale = 4'(sum_w - CW'(SLOT_COUNT));
                                end
                                else
                                begin
                                    end_next = sum_w;
                                end
                                cur_next   = CW'(pos_reg);
                                mem_raddr  = pos_reg;
                                state_next = S_FLAT;
                            end
                        end
                        CMD_RST_POS:
                        begin
                            pos_next = '0;
                        end
                        CMD_CLEAR:
                        begin
                            clr_addr_next = '0;
                            clr_ack_next  = 1'b1;
                            state_next    = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_RES;
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                // duplicate wins over full; otherwise insert at the lowest free entry
                if (row_dup)
                begin
                    res_next.accepted = 1'b1;
                end
                else if (!row_has_free)
                begin
                    res_next.slot_full = 1'b1;
                end
                else
                begin
                    res_next.accepted = 1'b1;
                    mem_we = 1'b1;
                    mem_wdata[row_free] = 1'b1;
                    mem_wdata[SLOT_CAPACITY + ID_W*row_free +: ID_W] = item_reg.tmr_id;
                end
                state_next = S_RES;
            end

            S_DEL:
            begin
                mem_we = 1'b1;
                mem_wdata[SLOT_CAPACITY-1:0] = row_mask & ~row_hit;
                state_next = S_RES;
            end

            S_FLAT:
            begin
                // latch the row and empty it in ram
                for (int i = 0; i < SLOT_CAPACITY; i++)
                begin
                    ids_next[i] = row_id[i];
                end
                mask_next  = row_mask;
                mem_we     = 1'b1;
                mem_waddr  = slot_of(cur_reg);
                mem_wdata  = '0;
                ridx_next  = '0;
                state_next = S_FRANK;
            end

            S_FRANK:
            begin
                rank_next[ridx_reg] = rank_cnt;
                if (ridx_reg == IW'(SLOT_CAPACITY - 1))
                begin
                    k_next     = '0;
                    state_next = S_FEMIT;
                end
                else
                begin
                    ridx_next = ridx_reg + IW'(1);
                end
            end

            S_FEMIT:
            begin
                if (k_reg != fire_n)
                begin
                    if (can_emit)
                    begin
                        out_load      = 1'b1;
                        out_data_next = make_res(KIND_FIRED, 1'b0, 1'b0, fire_id, level_reg,
                                                 1'b0, 4'd0, 1'b0);
                        k_next        = k_reg + RW'(1);
                    end
                end
                else if (cur_reg == end_reg)
                begin
                    pos_next   = slot_of(end_reg);
                    state_next = S_RES;
                end
                else
                begin
                    cur_next   = cur_reg + CW'(1);
                    mem_raddr  = slot_of(cur_reg + CW'(1));
                    state_next = S_FLAT;
                end
            end

            S_RES:
            begin
                if (can_emit)
                begin
                    out_load      = 1'b1;
                    out_data_next = res_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            pos_reg       <= '0;
            level_reg     <= 2'd0;
            clr_addr_reg  <= '0;
            clr_ack_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            clr_addr_reg  <= clr_addr_next;
            clr_ack_reg   <= clr_ack_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                level_reg <= cfg_wr_data;
            end
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cur_reg      <= cur_next;
        end_reg      <= end_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        ids_reg      <= ids_next;
        mask_reg     <= mask_next;
        rank_reg     <= rank_next;
        ridx_reg     <= ridx_next;
        k_reg        <= k_next;
    end

    // no ram write while waiting for a command
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
    else $error("ram written while idle");

    // a result never overwrites one that is still stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> !out_stall)
    else $error("output register overwritten under stall");

    // fired count never runs past the slot population
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FEMIT) |-> (k_reg <= fire_n))
    else $error("fired index beyond slot population");

    // position stays inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (32'(pos_reg) < 32'(SLOT_COUNT)))
    else $error("position outside ring");

endmodule

`default_nettype wire

// ===== sv/twr_ram.sv =====
// twr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module twr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== tb/tb_timer_wheel_ring.sv =====
// tb_timer_wheel_ring: self-checking regression for the timer wheel ring
// depends on twr_pkg and timer_wheel_ring; predicts every result and compares in order
`timescale 1ns / 1ps

module tb_timer_wheel_ring;
    import twr_pkg::*;

    localparam int SLOTS = 256;
    localparam int CAP = 4;
    localparam int CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [1:0] cfg_wr_data;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;

    in_item_t pending_cmds[$];
    out_item_t expected_results[$];
    int fail_count;
    int cycle_count;
    int sent_count;

    // predictor state
    logic [31:0] wheel_ids[SLOTS*CAP];
    logic wheel_valid[SLOTS*CAP];
    logic [7:0] wheel_pos;
    logic [1:0] wheel_level;

    // ids used in the random part, small pool so duplicates and deletes hit
    logic [31:0] id_pool[16];

    timer_wheel_ring i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic out_item_t make_result(logic [1:0] kind, logic acc, logic full,
                                              logic [31:0] id, logic [1:0] tag,
                                              logic wrap, logic [3:0] rem, logic lst);
        out_item_t r;
        r.kind = kind;
        r.accepted = acc;
        r.slot_full = full;
        r.fired_id = id;
        r.level_tag = tag;
        r.wrapped = wrap;
        r.remaining_scale = rem;
        r.last = lst;
        return r;
    endfunction

    // append one expected result transaction
    task automatic add_expect(input out_item_t r);
        begin
            expected_results.insert(expected_results.size(), r);
        end
    endtask

    // append one command to the send queue
    task automatic add_cmd(input in_item_t c);
        begin
            pending_cmds.insert(pending_cmds.size(), c);
        end
    endtask

    // fire one slot in ascending id order and empty it
    task automatic fire_slot_expect(input int s);
        logic [31:0] ids[$];
        begin
            for (int i = 0; i < CAP; i++)
            begin
                if (wheel_valid[s*CAP+i])
                begin
                    ids.insert(ids.size(), wheel_ids[s*CAP+i]);
                    wheel_valid[s*CAP+i] = 1'b0;
                end
            end
            ids.sort();
            foreach (ids[i])
                add_expect(make_result(KIND_FIRED, 1'b0, 1'b0, ids[i],
                                       wheel_level, 1'b0, 4'd0, 1'b0));
        end
    endtask

    // work out the results of one command and update the wheel copy
    task automatic predict_wheel(input in_item_t c);
        int s;
        int free_e;
        int sum;
        int end_slot;
        logic wrap;
        logic [3:0] rem;
        logic [3:0] sc;
        logic dup;
        begin
            s = int'(c.slot);
            case (c.command)
                CMD_ADD:
                begin
                    if (s == int'(wheel_pos) && wheel_level != 2'd0)
                        add_expect(make_result(KIND_ADD, 1'b0, 1'b0, 32'd0, 2'd0, 1'b0,
                                               4'd0, 1'b1));
                    else
                    begin
                        free_e = -1;
                        dup = 1'b0;
                        for (int i = 0; i < CAP; i++)
                        begin
                            if (wheel_valid[s*CAP+i])
                            begin
                                if (wheel_ids[s*CAP+i] == c.tmr_id)
                                    dup = 1'b1;
                            end
                            else if (free_e < 0)
                                free_e = i;
                        end
                        if (dup)
                            add_expect(make_result(KIND_ADD, 1'b1, 1'b0, 32'd0, 2'd0, 1'b0,
                                                   4'd0, 1'b1));
                        else if (free_e < 0)
                            add_expect(make_result(KIND_ADD, 1'b0, 1'b1, 32'd0, 2'd0, 1'b0,
                                                   4'd0, 1'b1));
                        else
                        begin
                            wheel_ids[s*CAP+free_e] = c.tmr_id;
                            wheel_valid[s*CAP+free_e] = 1'b1;
                            add_expect(make_result(KIND_ADD, 1'b1, 1'b0, 32'd0, 2'd0, 1'b0,
                                                   4'd0, 1'b1));
                        end
                    end
                end
                CMD_ADVANCE:
                begin
                    sc = (c.scale > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : c.scale;
                    sum = int'(wheel_pos) + int'(sc);
                    end_slot = sum;
                    wrap = 1'b0;
                    rem = 4'd0;
                    if (sum >= SLOTS)
                    begin
                        end_slot = SLOTS;
                        wrap = 1'b1;
                        rem = 4'(sum - SLOTS);
                    end
                    if (sc != 4'd0)
                        for (int p = int'(wheel_pos); p <= end_slot; p++)
                            fire_slot_expect(p % SLOTS);
                    wheel_pos = 8'(end_slot % SLOTS);
                    add_expect(make_result(KIND_END, 1'b0, 1'b0, 32'd0, 2'd0, wrap, rem, 1'b1));
                end
                default:
                begin
                    if (c.command == CMD_DELETE)
                    begin
                        for (int i = 0; i < CAP; i++)
                            if (wheel_valid[s*CAP+i] && wheel_ids[s*CAP+i] == c.tmr_id)
                                wheel_valid[s*CAP+i] = 1'b0;
                    end
                    else if (c.command == CMD_RST_POS)
                        wheel_pos = 8'd0;
                    else if (c.command == CMD_CLEAR)
                        foreach (wheel_valid[i])
                            wheel_valid[i] = 1'b0;
                    add_expect(make_result(KIND_ACK, 1'b0, 1'b0, 32'd0, 2'd0, 1'b0, 4'd0, 1'b1));
                end
            endcase
        end
    endtask

    function automatic in_item_t make_cmd(logic [2:0] cmd, logic [7:0] s,
                                          logic [31:0] id, logic [3:0] sc);
        in_item_t c;
        c.command = cmd;
        c.slot = s;
        c.tmr_id = id;
        c.scale = sc;
        return c;
    endfunction

    // driver: bursts of valid with random gaps, payload held while stalled
    int gap_left;
    int burst_left;

    logic was_accepted;
    always @(posedge clk)
        was_accepted <= in_valid && !in_stall && rst_n;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end
        else if (!in_valid || was_accepted)
        begin
            if (in_valid && was_accepted && burst_left > 0)
                burst_left = burst_left - 1;
            if (burst_left == 0 && gap_left == 0)
            begin
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                burst_left = $urandom_range(1, 10);
            end
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                in_data <= pending_cmds[0];
                predict_wheel(pending_cmds.pop_front());
                in_valid <= 1'b1;
                sent_count = sent_count + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern: phases of heavy, light and no stalling
    int stall_mode;
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
                fail_count = fail_count + 1;
            end
            else
            begin
                if (out_data !== expected_results[0])
                begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, expected_results[0], out_data);
                    fail_count = fail_count + 1;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timer_wheel_ring regression: fail");
            $finish;
        end
    end

    // wait for the queue and results to drain, then settle past the clear latency
    task automatic drain_wheel();
        begin
            while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
                @(posedge clk);
            repeat (SLOTS + 20) @(posedge clk);
        end
    endtask

    task automatic write_level(input logic [1:0] lvl);
        begin
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= lvl;
            @(negedge clk);
            cfg_wr_en <= 1'b0;
            wheel_level = lvl;
        end
    endtask

    // random phase: mostly add and advance on a small id pool near the position
    task automatic queue_random(input int n);
        int r;
        logic [7:0] s;
        logic [31:0] id;
        begin
            for (int k = 0; k < n; k++)
            begin
                r = $urandom_range(0, 99);
                s = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                : 8'(wheel_pos + $urandom_range(0, 20));
                id = ($urandom_range(0, 7) == 0) ? $urandom : id_pool[$urandom_range(0, 15)];
                if (r < 45)
                    add_cmd(make_cmd(CMD_ADD, s, id, 4'($urandom)));
                else if (r < 60)
                    add_cmd(make_cmd(CMD_DELETE, s, id, 4'($urandom)));
                else if (r < 90)
                    add_cmd(make_cmd(CMD_ADVANCE, 8'($urandom), $urandom, 4'($urandom)));
                else if (r < 95)
                    add_cmd(make_cmd(CMD_RST_POS, 8'($urandom), $urandom, 4'($urandom)));
                else if (r < 97)
                    add_cmd(make_cmd(CMD_CLEAR, 8'($urandom), $urandom, 4'($urandom)));
                else
                    add_cmd(make_cmd(3'($urandom_range(5, 7)), 8'($urandom),
                                     $urandom, 4'($urandom)));
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        cycle_count = 0;
        sent_count = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 2'd0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        wheel_pos = 8'd0;
        wheel_level = 2'd0;
        foreach (wheel_valid[i])
            wheel_valid[i] = 1'b0;
        foreach (id_pool[i])
            id_pool[i] = (i < 2) ? (i == 0 ? 32'h0 : 32'hFFFF_FFFF) : $urandom;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (SLOTS + 20) @(posedge clk);

        // directed: level 0 add at current slot, duplicates, full slot, ordering
        add_cmd(make_cmd(CMD_ADD, 8'd0, 32'hFFFF_FFFF, 4'd0));
        add_cmd(make_cmd(CMD_ADD, 8'd0, 32'h0, 4'd0));
        add_cmd(make_cmd(CMD_ADD, 8'd0, 32'h8000_0000, 4'd0));
        add_cmd(make_cmd(CMD_ADD, 8'd0, 32'h1234_5678, 4'd0));
        add_cmd(make_cmd(CMD_ADD, 8'd0, 32'h5555_AAAA, 4'd0));
        add_cmd(make_cmd(CMD_ADD, 8'd0, 32'h0, 4'd0));
        add_cmd(make_cmd(CMD_DELETE, 8'd0, 32'h7777_7777, 4'd0));
        add_cmd(make_cmd(CMD_DELETE, 8'd0, 32'h1234_5678, 4'd0));
        add_cmd(make_cmd(CMD_ADD, 8'd3, 32'hAAAA_5555, 4'd0));
        add_cmd(make_cmd(CMD_ADD, 8'd255, 32'h0000_0001, 4'd0));
        add_cmd(make_cmd(CMD_ADVANCE, 8'hFF, 32'hFFFF_FFFF, 4'd0));
        add_cmd(make_cmd(CMD_ADVANCE, 8'd0, 32'h0, 4'd5));
        add_cmd(make_cmd(CMD_ADVANCE, 8'd0, 32'h0, 4'd15));
        add_cmd(make_cmd(3'd5, 8'hFF, 32'hFFFF_FFFF, 4'hF));
        add_cmd(make_cmd(3'd7, 8'h00, 32'h0, 4'h0));
        add_cmd(make_cmd(CMD_RST_POS, 8'd0, 32'h0, 4'd0));
        add_cmd(make_cmd(CMD_ADD, 8'd10, 32'hDEAD_BEEF, 4'd0));
        add_cmd(make_cmd(CMD_CLEAR, 8'd0, 32'h0, 4'd0));
        add_cmd(make_cmd(CMD_ADVANCE, 8'd0, 32'h0, 4'd14));
        drain_wheel();

        // nonzero level: add at current slot refused, next slot fired by advance
        write_level(2'd3);
        add_cmd(make_cmd(CMD_ADD, 8'd14, 32'h42, 4'd0));
        add_cmd(make_cmd(CMD_ADD, 8'd15, 32'h43, 4'd0));
        add_cmd(make_cmd(CMD_ADVANCE, 8'd0, 32'h0, 4'd14));
        drain_wheel();

        // random phases across all levels
        for (int ph = 0; ph < 6; ph++)
        begin
            write_level((ph == 5) ? 2'd0 : 2'(ph % 4));
            queue_random(80);
            drain_wheel();
        end

        if (fail_count == 0)
            $display("timer_wheel_ring regression: pass");
        else
            $display("timer_wheel_ring regression: fail");
        $finish;
    end

endmodule

// ===== timer_wheel_ring.f =====
sv/twr_pkg.sv
sv/twr_ram.sv
sv/timer_wheel_ring.sv
tb/tb_timer_wheel_ring.sv
